/* rtl/smxent_pkg.sv */
// Constants and the exponential step table shared by the softmax entropy block.
`timescale 1ns / 1ps
package smxent_pkg;

	localparam int unsigned MAX_ELEMENTS = 4096;
	localparam int unsigned CNT_W        = 13;
	localparam logic [12:0] CUTOFF_Q8    = 13'd6144;
	localparam logic [31:0] ONE_Q30      = 32'd1073741824;
	localparam logic [63:0] HALF_Q30     = 64'd536870912;
	localparam logic [31:0] LN2_Q30      = 32'd744261118;
	localparam logic [15:0] LOGIT_MIN    = 16'h8000;

	// e^(-2^b/256) in Q2.30
	function automatic logic [31:0] exp_step(input logic [3:0] b);
		logic [31:0] v;
		case (b)
			4'd0:    v = 32'd1069555701;
			4'd1:    v = 32'd1065385899;
			4'd2:    v = 32'd1057095000;
			4'd3:    v = 32'd1040706261;
			4'd4:    v = 32'd1008687095;
			4'd5:    v = 32'd947573834;
			4'd6:    v = 32'd836230973;
			4'd7:    v = 32'd651257337;
			4'd8:    v = 32'd395007542;
			4'd9:    v = 32'd145315154;
			4'd10:   v = 32'd19666267;
			4'd11:   v = 32'd360200;
			4'd12:   v = 32'd121;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/softmax_entropy.sv */
// Softmax entropy of a logit vector, one pass, on one shared multiplier.
`timescale 1ns / 1ps
// Input channel: logit (Q8.8) and last, request taken when in_valid is high
// and in_stall is low. Output channel: entropy (Q4.12 nats), element_count
// and count_overflow, one request per vector, taken when out_valid is high
// and out_stall is low.
// Each logit runs through a sequencer around one 32x32 multiplier:
// an accept step, 13 exponential steps (one per offset bit), then one
// fall step for a falling or equal logit or three rise steps for a new
// maximum, and a close step; a logit past the cutoff or past the element
// limit goes from accept straight to close. The last logit adds the
// normalizing shifts until the top bit of the sum is set, 16 squaring
// steps for log2, a log scale step, a 45-step bit-serial restoring
// divider and an output step, which waits while out_stall holds the
// previous result.
// in_stall is high whenever the sequencer is busy.
// The result sits in an output register; while out_stall holds it, a new
// vector can still be taken, and its final result waits for the slot.
// Reset sets the running maximum to LOGIT_MIN and clears both sums, the count and out_valid.
module softmax_entropy
	import smxent_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] logit,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] entropy,
	output logic [12:0] element_count,
	output logic        count_overflow
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EXP, ST_RISE1, ST_RISE2, ST_RISE3, ST_FALL,
		ST_CLOSE, ST_NORM, ST_SQR, ST_LN, ST_DIV, ST_OUT
	} state_t;

	state_t             state_q;
	logic signed [15:0] max_q;
	logic [31:0]        s_q, w_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q, last_q;
	logic [15:0]        x_q;
	logic [12:0]        off_q;
	logic [30:0]        acc_q;
	logic [33:0]        ws_q;
	logic [5:0]         step_q;
	logic [31:0]        m_q;
	logic [4:0]         k_q;
	logic [15:0]        frac_q;
	logic signed [17:0] ln_q;
	logic [32:0]        rem_q;
	logic [44:0]        dvd_q;

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [16:0] t_val;
	logic [20:0] l2_mag;

	assign t_val = 17'((32'(acc_q) + 32'd8192) >> 14);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_EXP: begin
				mul_a = 32'(acc_q);
				mul_b = exp_step(step_q[3:0]);
			end
			ST_RISE1: begin
				mul_a = 32'(off_q);
				mul_b = s_q;
			end
			ST_RISE2: begin
				mul_a = s_q;
				mul_b = 32'(acc_q);
			end
			ST_RISE3: begin
				mul_a = ws_q[31:0];
				mul_b = 32'(acc_q);
			end
			ST_FALL: begin
				mul_a = 32'(t_val);
				mul_b = 32'(off_q);
			end
			ST_SQR: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_LN: begin
				mul_a = 32'(l2_mag);
				mul_b = LN2_Q30;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	// input decision
	logic signed [16:0] diff;
	logic [16:0]        fall_n;
	assign diff   = $signed({logit[15], logit}) - $signed({max_q[15], max_q});
	assign fall_n = 17'(-diff);

	// exponential step: round product back to Q30
	logic [63:0] exp_rnd;
	assign exp_rnd = (prod + HALF_Q30) >> 30;

	// rescale of the weighted sum operand, saturating at 2^34-1
	logic [63:0] ws_full;
	logic [33:0] ws_next;
	assign ws_full = 64'(w_q) + ((prod + 64'd128) >> 8);
	assign ws_next = (ws_full > 64'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : ws_full[33:0];

	// upper two bits of the operand times e, added above the low product
	logic [32:0] hi_prod;
	logic [64:0] w_full;
	assign hi_prod = ({2'b0, acc_q} & {33{ws_q[32]}}) + ({1'b0, acc_q, 1'b0} & {33{ws_q[33]}});
	assign w_full  = {1'b0, prod} + {hi_prod, 32'b0} + 65'(HALF_Q30);

	logic [31:0] s_scaled, w_scaled, s_plus_one;
	logic [32:0] s_one_sum;
	assign s_scaled   = (|exp_rnd[63:32]) ? 32'hFFFF_FFFF : exp_rnd[31:0];
	assign w_scaled   = (|w_full[64:62]) ? 32'hFFFF_FFFF : w_full[61:30];
	assign s_one_sum  = 33'(s_scaled) + 33'd65536;
	assign s_plus_one = s_one_sum[32] ? 32'hFFFF_FFFF : s_one_sum[31:0];

	// add of one term below the maximum
	logic [32:0] s_term_sum, w_term_sum;
	assign s_term_sum = 33'(s_q) + 33'(t_val);
	assign w_term_sum = 33'(w_q) + 33'((prod + 64'd128) >> 8);

	// squaring step of log2
	logic [31:0] sq_m;
	assign sq_m = prod[61:30];

	// log2 in Q16 and its magnitude
	logic signed [20:0] l2;
	logic [63:0]        ln_rnd;
	assign l2     = $signed({5'(k_q - 5'd16), frac_q});
	assign l2_mag = l2[20] ? 21'(-l2) : 21'(l2);
	assign ln_rnd = (prod + 64'h2_0000_0000) >> 34;

	// one restoring divide step
	logic [32:0] div_trial;
	logic        div_fit;
	assign div_trial = {rem_q[31:0], dvd_q[44]};
	assign div_fit   = div_trial >= {1'b0, s_q};

	// final sum and clamp
	logic signed [46:0] h_sum;
	logic [15:0]        h_clamp;
	assign h_sum   = $signed({2'b0, dvd_q}) + 47'(ln_q);
	assign h_clamp = h_sum[46] ? 16'd0 :
	                 (h_sum > 47'sd65535) ? 16'hFFFF : h_sum[15:0];

	assign in_stall = state_q != ST_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_q     <= $signed(LOGIT_MIN);
			s_q       <= '0;
			w_q       <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_OUT)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						x_q    <= logit;
						last_q <= last;
						step_q <= '0;
						acc_q  <= 31'(ONE_Q30);
						state_q <= ST_CLOSE;
						if (32'(cnt_q) < MAX_ELEMENTS) begin
							cnt_q <= cnt_q + 1'b1;
							if (diff > 0) begin
								if (diff > $signed({4'b0, CUTOFF_Q8})) begin
									s_q   <= 32'd65536;
									w_q   <= '0;
									max_q <= $signed(logit);
								end else begin
									off_q   <= diff[12:0];
									state_q <= ST_EXP;
								end
							end else if (fall_n <= {4'b0, CUTOFF_Q8}) begin
								off_q   <= fall_n[12:0];
								state_q <= ST_EXP;
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_EXP: begin
					if (off_q[step_q[3:0]])
						acc_q <= exp_rnd[30:0];
					step_q <= step_q + 1'b1;
					if (step_q == 6'd12)
						state_q <= ($signed(x_q) > max_q) ? ST_RISE1 : ST_FALL;
				end
				ST_RISE1: begin
					ws_q    <= ws_next;
					state_q <= ST_RISE2;
				end
				ST_RISE2: begin
					s_q     <= s_plus_one;
					state_q <= ST_RISE3;
				end
				ST_RISE3: begin
					w_q     <= w_scaled;
					max_q   <= $signed(x_q);
					state_q <= ST_CLOSE;
				end
				ST_FALL: begin
					s_q     <= s_term_sum[32] ? 32'hFFFF_FFFF : s_term_sum[31:0];
					w_q     <= w_term_sum[32] ? 32'hFFFF_FFFF : w_term_sum[31:0];
					state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (s_q == '0) begin
						dvd_q   <= '0;
						ln_q    <= '0;
						state_q <= ST_OUT;
					end else begin
						m_q     <= s_q;
						k_q     <= 5'd31;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (!m_q[31]) begin
						m_q <= m_q << 1;
						k_q <= k_q - 1'b1;
					end else begin
						m_q     <= m_q >> 1;
						frac_q  <= '0;
						step_q  <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					m_q    <= sq_m[31] ? {1'b0, sq_m[31:1]} : sq_m;
					frac_q <= {frac_q[14:0], sq_m[31]};
					step_q <= step_q + 1'b1;
					if (step_q == 6'd15)
						state_q <= ST_LN;
				end
				ST_LN: begin
					ln_q    <= l2[20] ? -$signed({1'b0, ln_rnd[16:0]})
					                  : $signed({1'b0, ln_rnd[16:0]});
					rem_q   <= '0;
					dvd_q   <= 45'({w_q, 12'b0}) + 45'(s_q >> 1);
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= div_fit ? div_trial - {1'b0, s_q} : div_trial;
					dvd_q  <= {dvd_q[43:0], div_fit};
					step_q <= step_q + 1'b1;
					if (step_q == 6'd44)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						entropy        <= h_clamp;
						element_count  <= cnt_q;
						count_overflow <= ovf_q;
						out_valid      <= 1'b1;
						max_q          <= $signed(LOGIT_MIN);
						s_q            <= '0;
						w_q            <= '0;
						cnt_q          <= '0;
						ovf_q          <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
